/* rtl/ddd_pkg.sv */
// ----------------------------------------------------------------------------
// ddd_pkg: shared types and constants of the date day difference block
// Field widths, request/response structs, the sequencer states, the
// month tables and the control structs of the divide-by-100 unit.
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int ORDER_W = 2;
   localparam int COUNT_W = 22;
   localparam int ORD_W   = 23;   // day ordinal of any 14-bit year fits here
   localparam int CSR_IDX_W = 2;

   localparam int MAX_YEAR_DEFAULT = 9999;
   localparam int COUNT_MAX = (2 ** COUNT_W) - 1;

   // Divide-by-100 unit: a 14-bit year gives a quotient below 2**8.
   // (y * 5243) >> 19 equals y / 100 over the whole 14-bit range.
   localparam int DIVISOR     = 100;
   localparam int QUOT_W      = 8;
   localparam int REM_W       = 7;
   localparam int RECIP       = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_DAY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MONTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_YEAR  = 2'd2;

   // Order codes
   localparam logic [ORDER_W-1:0] ORDER_BEFORE = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_SAME   = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_AFTER  = 2'd2;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [DAY_W-1:0]   query_day;
      logic [MONTH_W-1:0] query_month;
      logic [YEAR_W-1:0]  query_year;
   } ddd_req_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [COUNT_W-1:0] day_count;
      logic               invalid;
   } ddd_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_BASE,
      S_DAY,
      S_CMP,
      S_RESP
   } ddd_state_type;

   typedef struct packed {
      logic              load;
      logic [YEAR_W-1:0] dividend;
   } ddd_div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
      logic [REM_W-1:0]  rem;
   } ddd_div_stat_type;

   // Length of a month; months outside 1..12 give zero
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the months before m of a common year
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      unique case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

/* rtl/ddd_div100.sv */
// ----------------------------------------------------------------------------
// ddd_div100: registered divide of a year by 100
// Registers the year, then multiplies by a scaled reciprocal to get the
// quotient and the remainder. Shared by both dates.
// ----------------------------------------------------------------------------
module ddd_div100 (
   input  logic                      clock,
   input  logic                      reset,
   input  ddd_pkg::ddd_div_cmd_type  cmd,
   output ddd_pkg::ddd_div_stat_type stat
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ddd_pkg::YEAR_W-1:0]     dvnd_ff, dvnd_in;
   logic [ddd_pkg::QUOT_W-1:0]     quot_ff, quot_in;
   logic [ddd_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [ddd_pkg::PROD_W-1:0]     prod;
   logic [ddd_pkg::QUOT_W-1:0]     quot;
   logic [ddd_pkg::YEAR_W-1:0]     back;
   logic [ddd_pkg::REM_W-1:0]      rem;

   // quotient from the reciprocal, remainder from what is left over
   always_comb begin
      prod = ddd_pkg::PROD_W'(dvnd_ff) * ddd_pkg::PROD_W'(ddd_pkg::RECIP);
      quot = ddd_pkg::QUOT_W'(prod >> ddd_pkg::RECIP_SHIFT);
      back = ddd_pkg::YEAR_W'(quot) * ddd_pkg::YEAR_W'(ddd_pkg::DIVISOR);
      rem  = ddd_pkg::REM_W'(dvnd_ff - back);
   end

   always_comb begin
      busy_in = 1'b0;
      done_in = done_ff;
      dvnd_in = dvnd_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.load) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         dvnd_in = cmd.dividend;
      end else if (busy_ff) begin
         done_in = 1'b1;
         quot_in = quot;
         rem_in  = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvnd_ff <= dvnd_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;
   assign stat.rem  = rem_ff;

endmodule

/* rtl/date_day_difference.sv */
// ----------------------------------------------------------------------------
// date_day_difference: days between a query date and a reference date
// Orders a Gregorian query date against the configured reference date and
// gives the absolute day distance between them, flagging invalid queries.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_ready    req_data  (day, month, year)
//   rsp_      out        rsp_valid / rsp_ready    rsp_data  (order, count, invalid)
//   csr_      in         csr_wr_en, csr_index     csr_wdata (reference date)
//
// Each date passes through the divide-by-100 unit, then a base and a day
// step, and a compare step closes a valid query; an invalid query goes
// from the day step of the query date to the response. req_ready is high
// only in the idle state; a held response keeps the block from taking the
// next request until rsp_ready. Reset returns the sequencer to idle and
// loads the reference date 1 December 2000.
//
module date_day_difference #(
   parameter int MAX_YEAR = ddd_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ddd_pkg::ddd_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ddd_pkg::ddd_rsp_type            rsp_data,
   input  logic                            csr_wr_en,
   input  logic [ddd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ddd_pkg::YEAR_W-1:0]      csr_wdata
);

   localparam int ORD_W = ddd_pkg::ORD_W;

   ddd_pkg::ddd_state_type        state_ff, state_in;

   // reference date registers
   logic [ddd_pkg::DAY_W-1:0]     ref_day_ff;
   logic [ddd_pkg::MONTH_W-1:0]   ref_month_ff;
   logic [ddd_pkg::YEAR_W-1:0]    ref_year_ff;

   // working registers
   ddd_pkg::ddd_req_type          req_ff;
   logic                          sel_ff;        // 0 query pass, 1 reference pass
   logic [ddd_pkg::YEAR_W-1:0]    year_ff;
   logic [ORD_W-1:0]              acc_ff;
   logic                          leap_ff;
   logic [ORD_W-1:0]              ord_q_ff;
   ddd_pkg::ddd_rsp_type          rsp_ff, rsp_in;

   ddd_pkg::ddd_div_cmd_type      div_cmd;
   ddd_pkg::ddd_div_stat_type     div_stat;

   logic [ddd_pkg::YEAR_W-1:0]    ref_year_eff;
   logic [ddd_pkg::MONTH_W-1:0]   ref_month_eff;
   logic [ddd_pkg::DAY_W-1:0]     ref_lim;
   logic [ddd_pkg::DAY_W-1:0]     ref_day_eff;
   logic [ddd_pkg::MONTH_W-1:0]   cur_month;
   logic [ddd_pkg::DAY_W-1:0]     cur_day;
   logic                          query_bad;

   logic                          rem_nz;
   logic                          leap;
   logic [ORD_W-1:0]              l_four, l_cent, l_quad, base;
   logic [ORD_W-1:0]              ordinal;
   logic [ORD_W-1:0]              diff;

   // ---------------------------------------------------------------------
   // Configuration: reference date, indexes beyond the list are dropped
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_day_ff   <= 5'd1;
         ref_month_ff <= ddd_pkg::MONTH_DEC;
         ref_year_ff  <= 14'd2000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ddd_pkg::CSR_REF_DAY:   ref_day_ff   <= csr_wdata[ddd_pkg::DAY_W-1:0];
            ddd_pkg::CSR_REF_MONTH: ref_month_ff <= csr_wdata[ddd_pkg::MONTH_W-1:0];
            ddd_pkg::CSR_REF_YEAR:  ref_year_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the reference year and month into range
   always_comb begin
      if (32'(ref_year_ff) > MAX_YEAR) begin
         ref_year_eff = ddd_pkg::YEAR_W'(MAX_YEAR);
      end else begin
         ref_year_eff = ref_year_ff;
      end
      if (ref_month_ff < ddd_pkg::MONTH_JAN) begin
         ref_month_eff = ddd_pkg::MONTH_JAN;
      end else if (ref_month_ff > ddd_pkg::MONTH_DEC) begin
         ref_month_eff = ddd_pkg::MONTH_DEC;
      end else begin
         ref_month_eff = ref_month_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Shared divide-by-100 unit: splits each year into century and rest
   // ---------------------------------------------------------------------
   ddd_div100 u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // ---------------------------------------------------------------------
   // Year base: 365*y plus leap days before 1 January of year y, with
   // y = 100q + r:  ceil(y/4) - ceil(y/100) + ceil(y/400)
   // ---------------------------------------------------------------------
   always_comb begin
      rem_nz = div_stat.rem != '0;
      leap   = rem_nz ? (div_stat.rem[1:0] == 2'b00) : (div_stat.quot[1:0] == 2'b00);
      l_four = ORD_W'(div_stat.quot) * ORD_W'(25)
             + ORD_W'((div_stat.rem + 7'd3) >> 2);
      l_cent = ORD_W'(div_stat.quot) + ORD_W'(rem_nz);
      if (rem_nz) begin
         l_quad = ORD_W'(div_stat.quot >> 2) + ORD_W'(1);
      end else begin
         l_quad = ORD_W'((9'(div_stat.quot) + 9'd3) >> 2);
      end
      base = ORD_W'(year_ff) * ORD_W'(365) + l_four - l_cent + l_quad;
   end

   // ---------------------------------------------------------------------
   // Day step: validate the query or clamp the reference day, then add
   // the days of the year before the date
   // ---------------------------------------------------------------------
   always_comb begin
      ref_lim = ddd_pkg::month_days(ref_month_eff, leap_ff);
      if (ref_day_ff == '0) begin
         ref_day_eff = 5'd1;
      end else if (ref_day_ff > ref_lim) begin
         ref_day_eff = ref_lim;
      end else begin
         ref_day_eff = ref_day_ff;
      end

      if (sel_ff) begin
         cur_month = ref_month_eff;
         cur_day   = ref_day_eff;
      end else begin
         cur_month = req_ff.query_month;
         cur_day   = req_ff.query_day;
      end

      query_bad = (req_ff.query_month < ddd_pkg::MONTH_JAN)
               || (req_ff.query_month > ddd_pkg::MONTH_DEC)
               || (32'(req_ff.query_year) > MAX_YEAR)
               || (req_ff.query_day == '0)
               || (req_ff.query_day > ddd_pkg::month_days(req_ff.query_month, leap_ff));

      ordinal = acc_ff
              + ORD_W'(ddd_pkg::days_before(cur_month))
              + ORD_W'(leap_ff && (cur_month > ddd_pkg::MONTH_FEB))
              + ORD_W'(cur_day);
   end

   // ---------------------------------------------------------------------
   // Response: flag an invalid query, or compare the two ordinals and saturate the distance
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in = rsp_ff;
      diff   = '0;
      if (state_ff == ddd_pkg::S_DAY && !sel_ff && query_bad) begin
         rsp_in.order     = ddd_pkg::ORDER_BEFORE;
         rsp_in.day_count = '0;
         rsp_in.invalid   = 1'b1;
      end else if (state_ff == ddd_pkg::S_CMP) begin
         priority if (ord_q_ff < acc_ff) begin
            rsp_in.order = ddd_pkg::ORDER_BEFORE;
            diff         = acc_ff - ord_q_ff;
         end else if (ord_q_ff == acc_ff) begin
            rsp_in.order = ddd_pkg::ORDER_SAME;
         end else begin
            rsp_in.order = ddd_pkg::ORDER_AFTER;
            diff         = ord_q_ff - acc_ff;
         end
         if (diff > ORD_W'(ddd_pkg::COUNT_MAX)) begin
            rsp_in.day_count = '1;
         end else begin
            rsp_in.day_count = diff[ddd_pkg::COUNT_W-1:0];
         end
         rsp_in.invalid = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddd_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ddd_pkg::S_DIV;
            end
         end
         ddd_pkg::S_DIV: begin
            if (div_stat.done) begin
               state_in = ddd_pkg::S_BASE;
            end
         end
         ddd_pkg::S_BASE: state_in = ddd_pkg::S_DAY;
         ddd_pkg::S_DAY: begin
            priority if (sel_ff) begin
               state_in = ddd_pkg::S_CMP;
            end else if (query_bad) begin
               state_in = ddd_pkg::S_RESP;
            end else begin
               state_in = ddd_pkg::S_DIV;
            end
         end
         ddd_pkg::S_CMP: state_in = ddd_pkg::S_RESP;
         ddd_pkg::S_RESP: begin
            if (rsp_ready) begin
               state_in = ddd_pkg::S_IDLE;
            end
         end
         default: state_in = ddd_pkg::S_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_ready        = state_ff == ddd_pkg::S_IDLE;
      rsp_valid        = state_ff == ddd_pkg::S_RESP;
      div_cmd.load     = (state_ff == ddd_pkg::S_IDLE && req_valid)
                      || (state_ff == ddd_pkg::S_DAY && !sel_ff && !query_bad);
      div_cmd.dividend = (state_ff == ddd_pkg::S_IDLE) ? req_data.query_year
                                                       : ref_year_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ddd_pkg::S_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ddd_pkg::S_IDLE) begin
            sel_ff <= 1'b0;
         end else if (state_ff == ddd_pkg::S_DAY) begin
            sel_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // hold the request and the year under division
      if (state_ff == ddd_pkg::S_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (div_cmd.load) begin
         year_ff <= div_cmd.dividend;
      end
      // advance the ordinal accumulator
      if (state_ff == ddd_pkg::S_BASE) begin
         acc_ff  <= base;
         leap_ff <= leap;
      end else if (state_ff == ddd_pkg::S_DAY) begin
         if (sel_ff) begin
            acc_ff <= ordinal;
         end else begin
            ord_q_ff <= ordinal;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

/* rtl/ddd_checker.sv */
// ----------------------------------------------------------------------------
// ddd_checker: port-level checks of the date day difference block
// Watches the request and response channels and the response fields.
// ----------------------------------------------------------------------------
module ddd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ddd_pkg::ddd_rsp_type rsp_data
);

   // no response in the cycle after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one request at a time: never ready while a response waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // accepted request shows no response in the next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response too early after request");

   // invalid query carries a zero count and order before
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.invalid) |->
         (rsp_data.day_count == '0 && rsp_data.order == ddd_pkg::ORDER_BEFORE))
      else $error("invalid response with nonzero fields");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind date_day_difference ddd_checker u_ddd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/date_day_difference_tb.sv */
// ----------------------------------------------------------------------------
// date_day_difference_tb: self-checking regression of the date day difference
// Sends Gregorian query dates through the request channel against a series of
// reference dates. A local calendar model predicts order, day count and the
// invalid flag; every response is checked in order against it or a typed answer.
// ----------------------------------------------------------------------------
module date_day_difference_tb;
   import ddd_pkg::*;

   localparam int MAX_YEAR      = MAX_YEAR_DEFAULT;
   localparam int YEAR_TOP      = (1 << YEAR_W) - 1;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 52;
   localparam int SETTLE_CYCLES = 32;       // well past the running time of one request
   localparam int CYCLE_LIMIT   = 200000;

   // spare register index: the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one row of the directed part; answer is used only when typed is set
   typedef struct {
      ddd_req_type query;
      bit          typed;
      ddd_rsp_type answer;
   } probe_row_type;

   logic           clock = 1'b0;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   ddd_req_type    req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   ddd_rsp_type    rsp_data;
   logic           csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [YEAR_W-1:0]    csr_wdata;

   // reference date as the block should hold it, updated on every write
   logic [DAY_W-1:0]   cfg_day;
   logic [MONTH_W-1:0] cfg_month;
   logic [YEAR_W-1:0]  cfg_year;

   ddd_rsp_type   verdicts_due[$];
   probe_row_type probes[$];

   // typed answer of the request now on the bus, set together with its data
   bit            row_typed;
   ddd_rsp_type   row_answer;

   bit            gaps_on = 1'b1;
   int unsigned   cycle_count;
   int unsigned   fail_count;
   int unsigned   sent_count;
   int unsigned   checked_count;
   int unsigned   invalid_seen;
   int unsigned   order_seen[3];
   int unsigned   csr_writes;
   int unsigned   reference_count;

   date_day_difference #(
      .MAX_YEAR(MAX_YEAR)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Calendar model
   // ---------------------------------------------------------------------
   function automatic bit is_leap(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
   endfunction

   function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
      int unsigned len;
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = is_leap(y) ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   // days from the first of January of year zero up to the given date
   function automatic longint unsigned day_number(input int unsigned d, input int unsigned m,
                                                  input int unsigned y);
      longint unsigned yy;
      longint unsigned n;
      yy = y;
      n = 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400;
      for (int unsigned k = 1; k < m; k++)
         n += month_length(k, y);
      return n + d;
   endfunction

   function automatic ddd_rsp_type date_verdict(input ddd_req_type q);
      int unsigned     qd, qm, qy, rd, rm, ry, lim;
      longint unsigned a, b, span;
      ddd_rsp_type     v;
      qd = q.query_day;
      qm = q.query_month;
      qy = q.query_year;
      v.order     = ORDER_BEFORE;
      v.day_count = '0;
      v.invalid   = 1'b1;
      if (qm < MONTH_JAN || qm > MONTH_DEC || qy > MAX_YEAR || qd < 1 ||
          qd > month_length(qm, qy))
         return v;

      // clamp the reference into a real date
      ry = (cfg_year > MAX_YEAR) ? MAX_YEAR : cfg_year;
      rm = cfg_month;
      if (rm < MONTH_JAN) rm = MONTH_JAN;
      if (rm > MONTH_DEC) rm = MONTH_DEC;
      lim = month_length(rm, ry);
      rd = cfg_day;
      if (rd < 1) rd = 1;
      if (rd > lim) rd = lim;

      a = day_number(qd, qm, qy);
      b = day_number(rd, rm, ry);
      if (a < b) begin
         v.order = ORDER_BEFORE;
         span = b - a;
      end else if (a == b) begin
         v.order = ORDER_SAME;
         span = 0;
      end else begin
         v.order = ORDER_AFTER;
         span = a - b;
      end
      if (span > COUNT_MAX) span = COUNT_MAX;
      v.day_count = span[COUNT_W-1:0];
      v.invalid   = 1'b0;
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic probe_row_type probe(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
      probe_row_type r;
      r.query.query_day   = DAY_W'(d);
      r.query.query_month = MONTH_W'(m);
      r.query.query_year  = YEAR_W'(y);
      r.typed  = 1'b0;
      r.answer = '0;
      return r;
   endfunction

   function automatic probe_row_type probe_known(input int unsigned d, input int unsigned m,
                                                input int unsigned y,
                                                input logic [ORDER_W-1:0] ord,
                                                input int unsigned cnt, input bit inv);
      probe_row_type r;
      r = probe(d, m, y);
      r.typed            = 1'b1;
      r.answer.order     = ord;
      r.answer.day_count = COUNT_W'(cnt);
      r.answer.invalid   = inv;
      return r;
   endfunction

   // mostly real dates, some with one field just out of range, some raw bits
   function automatic ddd_req_type random_query();
      ddd_req_type q;
      int unsigned pick, y, m, len;
      int          near_year;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         near_year = (cfg_year > MAX_YEAR) ? MAX_YEAR : int'(cfg_year);
         near_year = near_year + int'($urandom_range(0, 8)) - 4;
         if (near_year < 0) near_year = 0;
         if (near_year > MAX_YEAR) near_year = MAX_YEAR;
         y = near_year;
      end else begin
         y = $urandom_range(0, MAX_YEAR);
      end
      m   = $urandom_range(MONTH_JAN, MONTH_DEC);
      len = month_length(m, y);
      q.query_year  = YEAR_W'(y);
      q.query_month = MONTH_W'(m);
      q.query_day   = ($urandom_range(0, 3) == 0) ? DAY_W'(len)
                                                  : DAY_W'($urandom_range(1, len));
      if (pick >= 85) begin
         q.query_day   = DAY_W'($urandom);
         q.query_month = MONTH_W'($urandom);
         q.query_year  = YEAR_W'($urandom);
      end else if (pick >= 70) begin
         case ($urandom_range(0, 3))
            0: q.query_day = '0;
            1: begin
               if (len < 31)
                  q.query_day = DAY_W'($urandom_range(len + 1, 31));
               else
                  q.query_month = MONTH_W'($urandom_range(MONTH_DEC + 1, 15));
            end
            2: q.query_month = ($urandom_range(0, 1) == 0) ?
                                  '0 : MONTH_W'($urandom_range(MONTH_DEC + 1, 15));
            default: q.query_year = YEAR_W'($urandom_range(MAX_YEAR + 1, YEAR_TOP));
         endcase
      end
      return q;
   endfunction

   // raise valid at a falling edge and hold it until the request is taken;
   // valid stays high on return so back-to-back requests never glitch it
   task automatic send_query(input ddd_req_type q, input bit typed, input ddd_rsp_type answer);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      row_typed  = typed;
      row_answer = answer;
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // drop valid and hold off until every predicted response is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [YEAR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   // junk in the unused upper bits checks that day and month are masked
   task automatic set_reference(input int unsigned d, input int unsigned m, input int unsigned y);
      write_csr(CSR_REF_DAY, {9'($urandom), DAY_W'(d)});
      write_csr(CSR_REF_MONTH, {10'($urandom), MONTH_W'(m)});
      write_csr(CSR_REF_YEAR, YEAR_W'(y));
      reference_count++;
   endtask

   task automatic report_field(input string field, input int unsigned want,
                               input int unsigned got);
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall in short random bursts while gaps are enabled
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: track register writes, predict on accept, check on response
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ddd_rsp_type want;
      if (reset) begin
         cfg_day   = DAY_W'(1);
         cfg_month = MONTH_DEC;
         cfg_year  = YEAR_W'(2000);
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REF_DAY:   cfg_day   = csr_wdata[DAY_W-1:0];
               CSR_REF_MONTH: cfg_month = csr_wdata[MONTH_W-1:0];
               CSR_REF_YEAR:  cfg_year  = csr_wdata;
               default: ;     // unused index: leave the reference alone
            endcase
         end
         if (req_valid && req_ready)
            verdicts_due.push_back(row_typed ? row_answer : date_verdict(req_data));
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response: expected none, actual %0d/%0d/%0d",
                        $time, rsp_data.order, rsp_data.day_count, rsp_data.invalid);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.order != want.order)
                  report_field("order", want.order, rsp_data.order);
               if (rsp_data.day_count != want.day_count)
                  report_field("day_count", want.day_count, rsp_data.day_count);
               if (rsp_data.invalid != want.invalid)
                  report_field("invalid", want.invalid, rsp_data.invalid);
               checked_count++;
               if (want.invalid)
                  invalid_seen++;
               else if (want.order <= ORDER_AFTER)
                  order_seen[want.order]++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, verdicts_due.size());
         $display("date_day_difference regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int unsigned phase;
      int unsigned i;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      row_typed  = 1'b0;
      row_answer = '0;

      // Directed rows against the reset reference, 1 December 2000.
      probes.push_back(probe_known(1, 12, 2000, ORDER_SAME, 0, 1'b0));
      probes.push_back(probe_known(2, 12, 2000, ORDER_AFTER, 1, 1'b0));
      probes.push_back(probe_known(30, 11, 2000, ORDER_BEFORE, 1, 1'b0));
      probes.push_back(probe_known(1, 1, 2001, ORDER_AFTER, 31, 1'b0));
      probes.push_back(probe_known(31, 12, 2000, ORDER_AFTER, 30, 1'b0));
      probes.push_back(probe_known(1, 12, 1999, ORDER_BEFORE, 366, 1'b0));
      // rejected queries: zero day, day past month end, non-leap century,
      // month out of range, year past the limit, all-zero fields
      probes.push_back(probe_known(0, 5, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(31, 4, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(29, 2, 1900, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(30, 2, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(29, 2, 2100, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(1, 0, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(1, 13, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(31, 15, 2000, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(1, 1, MAX_YEAR + 1, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(31, 12, YEAR_TOP, ORDER_BEFORE, 0, 1'b1));
      probes.push_back(probe_known(0, 0, 0, ORDER_BEFORE, 0, 1'b1));
      // leap-year edges, year zero, the far ends of the range and two plain dates
      probes.push_back(probe(29, 2, 2000));
      probes.push_back(probe(29, 2, 2024));
      probes.push_back(probe(28, 2, 2100));
      probes.push_back(probe(1, 1, 0));
      probes.push_back(probe(29, 2, 0));
      probes.push_back(probe(31, 12, MAX_YEAR));
      probes.push_back(probe(31, 1, 2000));
      probes.push_back(probe(30, 6, 1987));

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (probes[k])
         send_query(probes[k].query, probes[k].typed, probes[k].answer);

      // a write to the spare index must leave the reference untouched
      wait_drained();
      write_csr(CSR_UNUSED, YEAR_W'($urandom));
      repeat (10) send_query(random_query(), 1'b0, '0);

      // One reference per phase: extremes and clamped settings first,
      // then random ones. Phase 6 and the last phase run without the random gaps on either channel.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         gaps_on = (phase != 6) && (phase != NUM_PHASES - 1);
         case (phase)
            0: set_reference(1, MONTH_JAN, 0);
            1: set_reference(31, MONTH_DEC, MAX_YEAR);
            2: set_reference(0, 0, YEAR_TOP);             // clamp every field
            3: set_reference(31, MONTH_FEB, 2100);        // day clamps to the 28th
            4: set_reference(31, MONTH_FEB, 2000);        // day clamps to the 29th
            5: set_reference(30, 15, 1900);               // month clamps to December
            default: begin
               if ($urandom_range(0, 2) == 0) begin
                  set_reference($urandom_range(0, 31), $urandom_range(0, 15),
                                $urandom_range(0, YEAR_TOP));
               end else begin
                  i = $urandom_range(MONTH_JAN, MONTH_DEC);
                  set_reference($urandom_range(1, 28), i, $urandom_range(0, MAX_YEAR));
               end
            end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // hold off now and then until the block has answered everything
            if ((phase == 2 && i == PHASE_ITEMS / 2) || $urandom_range(0, 39) == 0)
               wait_drained();
            send_query(random_query(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d requests, %0d responses checked over %0d reference dates",
               sent_count, checked_count, reference_count + 1);
      $display("before %0d, same %0d, after %0d, invalid %0d; %0d register writes",
               order_seen[ORDER_BEFORE], order_seen[ORDER_SAME], order_seen[ORDER_AFTER],
               invalid_seen, csr_writes);
      if (fail_count == 0)
         $display("date_day_difference regression: pass");
      else
         $display("date_day_difference regression: fail");
      $finish;
   end

endmodule
